// ===== rtl/two_class_min_key_selector_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-class min-key selector
// Clocked on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_MIN_KEY_SELECTOR_TOP_MACROS_SVH
`define TWO_CLASS_MIN_KEY_SELECTOR_TOP_MACROS_SVH

// Condition that must hold at every edge.
`define TCMKS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define TCMKS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcmks_pkg.sv =====
// ----------------------------------------------------------------------------
// tcmks_pkg
// Shared sizes, codes, payload types and helper functions of the selector.
// ----------------------------------------------------------------------------
package tcmks_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 10;
    localparam int KEY_W       = 10;
    localparam int SVC_W       = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 10;

    localparam logic [KEY_W-1:0] KEY_LIMIT = KEY_W'(1000);

    // floor(x / 3) = (x * 683) >> 11 for any 10-bit x
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;

    // operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // classes handed from front to back
    localparam logic [1:0] CLS_ADD    = 2'd0;
    localparam logic [1:0] CLS_FINISH = 2'd1;
    localparam logic [1:0] CLS_QUERY  = 2'd2;

    // key select modes
    localparam logic [1:0] MODE_PRIORITY = 2'd0;
    localparam logic [1:0] MODE_SERVICE  = 2'd1;
    localparam logic [1:0] MODE_ID       = 2'd2;
    localparam logic [1:0] MODE_DEADLINE = 2'd3;

    // speed classes
    localparam logic [1:0] KIND_NORMAL  = 2'd0;
    localparam logic [1:0] KIND_FISHING = 2'd1;
    localparam logic [1:0] KIND_PATROL  = 2'd2;

    // sides
    localparam logic [1:0] SIDE_LEFT  = 2'd0;
    localparam logic [1:0] SIDE_RIGHT = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_WIDTH = 1'd1;

    typedef struct packed {
        logic [1:0]      operation;
        logic [ID_W-1:0] job_id;
        logic [1:0]      job_kind;
        logic [1:0]      job_side;
        logic [KEY_W-1:0] job_priority;
        logic [KEY_W-1:0] job_deadline;
    } in_item_t;

    typedef struct packed {
        logic            accepted;
        logic            left_valid;
        logic [ID_W-1:0] left_id;
        logic            right_valid;
        logic [ID_W-1:0] right_id;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [1:0]       side;
        logic [KEY_W-1:0] priority_key;
        logic [KEY_W-1:0] deadline;
        logic [SVC_W-1:0] service;
        logic             done;
    } entry_t;

    typedef struct packed {
        logic [1:0]       cls;
        logic [ID_W-1:0]  id;
        logic [1:0]       side;
        logic [KEY_W-1:0] priority_key;
        logic [KEY_W-1:0] deadline;
        logic [SVC_W-1:0] service;
    } work_t;

    function automatic logic [SVC_W-1:0] service_time(input logic [SVC_W-1:0] width,
                                                      input logic [1:0] kind);
        logic [2*SVC_W-1:0] prod;
        begin
            prod = {{SVC_W{1'b0}}, width} * (2*SVC_W)'(DIV3_MUL);
            case (kind)
                KIND_FISHING: service_time = width >> 1;
                KIND_PATROL:  service_time = SVC_W'(prod >> DIV3_SHIFT);
                default:      service_time = width;
            endcase
        end
    endfunction

    function automatic logic [KEY_W-1:0] key_of(input entry_t e, input logic [1:0] mode);
        begin
            case (mode)
                MODE_PRIORITY: key_of = e.priority_key;
                MODE_SERVICE:  key_of = e.service;
                MODE_ID:       key_of = e.id;
                MODE_DEADLINE: key_of = e.deadline;
                default:       key_of = e.deadline;
            endcase
        end
    endfunction

endpackage

// ===== rtl/tcmks_front.sv =====
// ----------------------------------------------------------------------------
// tcmks_front
// Accepts input beats, classifies the operation, works out the service time
// and holds the classified work in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tcmks_front
    import tcmks_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  in_item_t         item,
    input  logic [SVC_W-1:0] channel_width,
    input  logic             take,
    output logic             work_valid,
    output work_t            work
);

    work_t      q_mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push_ok;
    logic       pop_ok;
    work_t      classified;

    always_comb
    begin
        case (item.operation)
            OP_ADD:    classified.cls = CLS_ADD;
            OP_FINISH: classified.cls = CLS_FINISH;
            default:   classified.cls = CLS_QUERY;
        endcase
        classified.id           = item.job_id;
        classified.side         = item.job_side;
        classified.priority_key = item.job_priority;
        classified.deadline     = item.job_deadline;
        classified.service      = service_time(channel_width, item.job_kind);
    end

    assign full       = (fill_reg == 2'd2);
    assign work_valid = (fill_reg != 2'd0);
    assign work       = q_mem[rd_ptr_reg];
    assign push_ok    = push && !full;
    assign pop_ok     = take && work_valid;

    always_comb
    begin
        wr_ptr_next = push_ok ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_ok ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_ok && !pop_ok)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop_ok && !push_ok)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_mem[wr_ptr_reg] <= classified;
        end
    end

endmodule

// ===== rtl/tcmks_back.sv =====
// ----------------------------------------------------------------------------
// tcmks_back
// Owns the job table. For each work beat it scans the used entries once,
// finding the id and keeping the per-side minimum, marks a finished job,
// appends an added job, and parks the result in an output register.
// ----------------------------------------------------------------------------
module tcmks_back
    import tcmks_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] select_mode,
    input  logic       work_valid,
    input  work_t      work,
    output logic       take,
    output logic       empty,
    input  logic       pop,
    output out_item_t  result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    entry_t mem [TABLE_DEPTH];

    logic [1:0]       state_reg,  state_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic [CNT_W-1:0] addr_reg,   addr_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    entry_t           rd_data_reg;
    work_t            job_reg,    job_next;
    logic             found_reg,  found_next;
    logic             acc_reg,    acc_next;
    logic             lv_reg,     lv_next;
    logic [ID_W-1:0]  lid_reg,    lid_next;
    logic [KEY_W-1:0] lbest_reg,  lbest_next;
    logic             rv_reg,     rv_next;
    logic [ID_W-1:0]  rid_reg,    rid_next;
    logic [KEY_W-1:0] rbest_reg,  rbest_next;
    logic             res_vld_reg, res_vld_next;
    out_item_t        res_reg,    res_next;

    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             match;
    logic             drop_entry;
    logic [KEY_W-1:0] cur_key;
    entry_t           new_ent;
    logic [KEY_W-1:0] new_key;
    logic             append_ok;
    logic             res_space;
    out_item_t        fin;

    assign empty     = !res_vld_reg;
    assign result    = res_reg;
    assign res_space = !res_vld_reg || pop;

    always_comb
    begin
        new_ent.id           = job_reg.id;
        new_ent.side         = job_reg.side;
        new_ent.priority_key = job_reg.priority_key;
        new_ent.deadline     = job_reg.deadline;
        new_ent.service      = job_reg.service;
        new_ent.done         = 1'b0;
    end

    assign new_key   = key_of(new_ent, select_mode);
    assign append_ok = (job_reg.cls == CLS_ADD) && !found_reg
                       && (cnt_reg < CNT_W'(TABLE_DEPTH));
    assign match     = (rd_data_reg.id == job_reg.id) && !found_reg;
    assign cur_key   = key_of(rd_data_reg, select_mode);
    assign drop_entry = rd_data_reg.done
                        || (match && (job_reg.cls == CLS_FINISH));

    // final result, including a freshly appended entry, which comes last
    always_comb
    begin
        fin.accepted    = acc_reg || append_ok;
        fin.left_valid  = lv_reg;
        fin.left_id     = lid_reg;
        fin.right_valid = rv_reg;
        fin.right_id    = rid_reg;
        if (append_ok)
        begin
            if ((new_ent.side == SIDE_RIGHT) && (new_key < rbest_reg))
            begin
                fin.right_valid = 1'b1;
                fin.right_id    = new_ent.id;
            end
            else if ((new_ent.side == SIDE_LEFT) && (new_key < lbest_reg))
            begin
                fin.left_valid = 1'b1;
                fin.left_id    = new_ent.id;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        addr_next    = addr_reg;
        rd_vld_next  = 1'b0;
        rd_idx_next  = rd_idx_reg;
        job_next     = job_reg;
        found_next   = found_reg;
        acc_next     = acc_reg;
        lv_next      = lv_reg;
        lid_next     = lid_reg;
        lbest_next   = lbest_reg;
        rv_next      = rv_reg;
        rid_next     = rid_reg;
        rbest_next   = rbest_reg;
        res_vld_next = res_vld_reg && !pop;
        res_next     = res_reg;
        take         = 1'b0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = rd_idx_reg;
        wr_data      = rd_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (work_valid)
                begin
                    take       = 1'b1;
                    job_next   = work;
                    addr_next  = '0;
                    found_next = 1'b0;
                    acc_next   = 1'b0;
                    lv_next    = 1'b0;
                    lid_next   = '0;
                    lbest_next = KEY_LIMIT;
                    rv_next    = 1'b0;
                    rid_next   = '0;
                    rbest_next = KEY_LIMIT;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle over the used entries
                if (addr_reg < cnt_reg)
                begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = addr_reg[IDX_W-1:0];
                    addr_next   = addr_reg + CNT_W'(1);
                end
                else if (!rd_vld_reg)
                begin
                    state_next = ST_DONE;
                end
                if (rd_vld_reg)
                begin
                    if (match)
                    begin
                        found_next = 1'b1;
                    end
                    // first entry with the id: mark it done, drop it from the pick
                    if (match && (job_reg.cls == CLS_FINISH) && !rd_data_reg.done)
                    begin
                        wr_en        = 1'b1;
                        wr_data.done = 1'b1;
                        acc_next     = 1'b1;
                    end
                    if (!drop_entry)
                    begin
                        if ((rd_data_reg.side == SIDE_RIGHT) && (cur_key < rbest_reg))
                        begin
                            rbest_next = cur_key;
                            rv_next    = 1'b1;
                            rid_next   = rd_data_reg.id;
                        end
                        else if ((rd_data_reg.side == SIDE_LEFT)
                                 && (cur_key < lbest_reg))
                        begin
                            lbest_next = cur_key;
                            lv_next    = 1'b1;
                            lid_next   = rd_data_reg.id;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                // hold until the output register frees up
                if (res_space)
                begin
                    if (append_ok)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = cnt_reg[IDX_W-1:0];
                        wr_data  = new_ent;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    res_vld_next = 1'b1;
                    res_next     = fin;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_vld_reg  <= rd_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        rd_idx_reg <= rd_idx_next;
        job_reg    <= job_next;
        found_reg  <= found_next;
        acc_reg    <= acc_next;
        lv_reg     <= lv_next;
        lid_reg    <= lid_next;
        lbest_reg  <= lbest_next;
        rv_reg     <= rv_next;
        rid_reg    <= rid_next;
        rbest_reg  <= rbest_next;
        res_reg    <= res_next;
    end

    // job table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr_reg[IDX_W-1:0]];
        end
    end

endmodule

// ===== rtl/two_class_min_key_selector_top.sv =====
// ----------------------------------------------------------------------------
// two_class_min_key_selector_top
// Job table with a per-side (left/right) minimum-key pick after every item.
// ----------------------------------------------------------------------------
// Input channel: drive item and raise push; the beat is taken on an edge
// with push high and full low. A two-entry queue sits in front, so items
// can be pushed while the back end is still scanning.
// Result channel: while empty is low the oldest result is on result; it
// leaves on an edge with pop high. One result beat per input beat.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (select_mode, channel_width) at the edge; write only while idle.
// Timing: each item scans every used table entry once, one entry per cycle
// through the table's single read port. Items are worked one at a time: the
// back end takes the next item from the queue only once it is done with the
// last one, while the queue can still take new items.
// Reset: clears the job count, the queues and both registers; the table
// needs no clearing since only entries below the count are ever read.
// Stall: a result not popped is held; the back end then waits with the next
// result, and the input queue fills and raises full.
// ----------------------------------------------------------------------------
`include "two_class_min_key_selector_top_macros.svh"

module two_class_min_key_selector_top
    import tcmks_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  in_item_t              item,
    output logic                  empty,
    input  logic                  pop,
    output out_item_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [1:0]       select_mode_reg;
    logic [SVC_W-1:0] channel_width_reg;
    logic             work_valid;
    work_t            work;
    logic             take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_mode_reg   <= MODE_PRIORITY;
            channel_width_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SELECT_MODE:   select_mode_reg   <= cfg_data[1:0];
                CFG_CHANNEL_WIDTH: channel_width_reg <= cfg_data[SVC_W-1:0];
                default:           ;
            endcase
        end
    end

    tcmks_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .item          (item),
        .channel_width (channel_width_reg),
        .take          (take),
        .work_valid    (work_valid),
        .work          (work)
    );

    tcmks_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .select_mode (select_mode_reg),
        .work_valid  (work_valid),
        .work        (work),
        .take        (take),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

    `TCMKS_ASSERT_IMPLY(a_take_needs_work, take, work_valid, "back took from an empty queue")
    `TCMKS_ASSERT_IMPLY(a_full_has_work, full, work_valid, "queue full but no work shown")
    `TCMKS_ASSERT_ALWAYS(a_no_left_id, empty || result.left_valid || (result.left_id == '0), "left id set without a pick")
    `TCMKS_ASSERT_ALWAYS(a_no_right_id, empty || result.right_valid || (result.right_id == '0), "right id set without a pick")

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives job adds, finishes and queries into the two-class selector through
// its push/full port and checks each result beat against a predictor that
// keeps its own job table. A short table of directed rows comes first. Then
// eight random phases follow, each under a new select mode and channel width.
// The sender idles in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;
    import tcmks_pkg::*;

    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [1:0] SIDE_OTHER = 2'd2;
    localparam logic [1:0] SIDE_SPARE = 2'd3;

    localparam int DIR_N       = 17;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 178;
    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_CYCLES = 600;
    localparam int HOLD_AT     = 300;
    localparam int TAIL_CYCLES = 150;

    typedef struct packed {
        in_item_t  stim;
        logic      known;
        out_item_t want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    in_item_t              item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    out_item_t             result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    two_class_min_key_selector_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [ID_W-1:0]  tbl_id   [TABLE_DEPTH];
    logic [1:0]       tbl_side [TABLE_DEPTH];
    logic [KEY_W-1:0] tbl_prio [TABLE_DEPTH];
    logic [KEY_W-1:0] tbl_dl   [TABLE_DEPTH];
    logic [SVC_W-1:0] tbl_svc  [TABLE_DEPTH];
    logic             tbl_done [TABLE_DEPTH];
    int               job_total = 0;
    int               cur_mode = 0;
    int               cur_width = 0;

    out_item_t pending_picks [$];
    int        mismatches = 0;
    int        burst_left = 0;

    dir_row_t dir_rows [DIR_N];
    int       phase_mode  [PHASES];
    int       phase_width [PHASES];
    int       phase_add   [PHASES];

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int find_job(input logic [ID_W-1:0] id);
        for (int i = 0; i < job_total; i++)
            if (tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    // Apply one job item to the table and work out the per-side pick.
    task automatic apply_job_item(input in_item_t it, output out_item_t pick);
        int slot;
        int speed;
        int key;
        int best_l;
        int best_r;
        pick = '0;
        slot = find_job(it.job_id);
        case (it.operation)
            OP_ADD:
            begin
                if (slot < 0 && job_total < TABLE_DEPTH)
                begin
                    speed = (it.job_kind == KIND_PATROL) ? 3 :
                            (it.job_kind == KIND_FISHING) ? 2 : 1;
                    tbl_id[job_total]   = it.job_id;
                    tbl_side[job_total] = it.job_side;
                    tbl_prio[job_total] = it.job_priority;
                    tbl_dl[job_total]   = it.job_deadline;
                    tbl_svc[job_total]  = SVC_W'(cur_width / speed);
                    tbl_done[job_total] = 1'b0;
                    job_total++;
                    pick.accepted = 1'b1;
                end
            end
            OP_FINISH:
            begin
                if (slot >= 0 && !tbl_done[slot])
                begin
                    tbl_done[slot] = 1'b1;
                    pick.accepted = 1'b1;
                end
            end
            default: ;
        endcase
        best_l = KEY_LIMIT;
        best_r = KEY_LIMIT;
        for (int i = 0; i < job_total; i++)
        begin
            if (tbl_done[i])
                continue;
            case (2'(cur_mode))
                MODE_PRIORITY: key = tbl_prio[i];
                MODE_SERVICE:  key = tbl_svc[i];
                MODE_ID:       key = tbl_id[i];
                default:       key = tbl_dl[i];
            endcase
            // earlier entry keeps a tie
            if (tbl_side[i] == SIDE_RIGHT && key < best_r)
            begin
                best_r = key;
                pick.right_valid = 1'b1;
                pick.right_id = tbl_id[i];
            end
            else if (tbl_side[i] == SIDE_LEFT && key < best_l)
            begin
                best_l = key;
                pick.left_valid = 1'b1;
                pick.left_id = tbl_id[i];
            end
        end
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return KEY_W'($urandom_range(0, 31));
        else if (roll < 85)
            return KEY_W'($urandom_range(0, 1023));
        return KEY_W'($urandom_range(995, 1023));
    endfunction

    function automatic in_item_t make_item(input int add_pct);
        in_item_t it;
        int roll;
        it.job_id       = ID_W'($urandom_range(0, 1023));
        it.job_kind     = 2'($urandom_range(0, 3));
        it.job_side     = 2'($urandom_range(0, 3));
        it.job_priority = KEY_W'($urandom_range(0, 1023));
        it.job_deadline = KEY_W'($urandom_range(0, 1023));
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
        begin
            it.operation = OP_ADD;
            roll = $urandom_range(0, 19);
            it.job_side = (roll < 9) ? SIDE_LEFT : (roll < 18) ? SIDE_RIGHT : it.job_side;
            it.job_priority = random_key();
            it.job_deadline = random_key();
            if ($urandom_range(0, 9) == 0)
                it.job_id = ID_W'($urandom_range(990, 1023));
            // re-add a known id now and then
            if (job_total > 0 && $urandom_range(0, 4) == 0)
                it.job_id = tbl_id[$urandom_range(0, job_total - 1)];
        end
        else if (roll < add_pct + 10)
        begin
            it.operation = OP_FINISH;
            if (job_total > 0 && $urandom_range(0, 9) < 7)
                it.job_id = tbl_id[$urandom_range(0, job_total - 1)];
        end
        else if (roll < add_pct + 13)
            it.operation = OP_SPARE;
        else
            it.operation = OP_QUERY;
        return it;
    endfunction

    // Offer one beat, idling first when the burst runs out.
    task automatic offer(input in_item_t it, input logic known, input out_item_t want);
        out_item_t pick;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        apply_job_item(it, pick);
        pending_picks.push_back(known ? want : pick);
    endtask

    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        while (pending_picks.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_SELECT_MODE)
            cur_mode = data;
        else
            cur_width = data;
    endtask

    initial
    begin
        dir_rows[0]  = {{OP_QUERY, 10'd0, KIND_NORMAL, SIDE_LEFT, 10'd0, 10'd0},
                        1'b1, {1'b0, 1'b0, 10'd0, 1'b0, 10'd0}};
        dir_rows[1]  = {{OP_FINISH, 10'd1023, KIND_SPARE, SIDE_SPARE, 10'd1023, 10'd1023},
                        1'b1, {1'b0, 1'b0, 10'd0, 1'b0, 10'd0}};
        dir_rows[2]  = {{OP_ADD, 10'd1023, KIND_NORMAL, SIDE_LEFT, 10'd0, 10'd1023},
                        1'b1, {1'b1, 1'b1, 10'd1023, 1'b0, 10'd0}};
        dir_rows[3]  = {{OP_ADD, 10'd1023, KIND_FISHING, SIDE_RIGHT, 10'd0, 10'd0},
                        1'b1, {1'b0, 1'b1, 10'd1023, 1'b0, 10'd0}};
        dir_rows[4]  = {{OP_ADD, 10'd0, KIND_PATROL, SIDE_RIGHT, 10'd1023, 10'd0},
                        1'b1, {1'b1, 1'b1, 10'd1023, 1'b0, 10'd0}};
        dir_rows[5]  = {{OP_ADD, 10'd5, KIND_PATROL, SIDE_RIGHT, 10'd999, 10'd1000},
                        1'b1, {1'b1, 1'b1, 10'd1023, 1'b1, 10'd5}};
        dir_rows[6]  = {{OP_ADD, 10'd6, KIND_FISHING, SIDE_RIGHT, 10'd999, 10'd999},
                        1'b1, {1'b1, 1'b1, 10'd1023, 1'b1, 10'd5}};
        dir_rows[7]  = {{OP_ADD, 10'd7, KIND_NORMAL, SIDE_OTHER, 10'd0, 10'd0},
                        1'b1, {1'b1, 1'b1, 10'd1023, 1'b1, 10'd5}};
        dir_rows[8]  = {{OP_ADD, 10'd8, KIND_SPARE, SIDE_SPARE, 10'd0, 10'd0},
                        1'b1, {1'b1, 1'b1, 10'd1023, 1'b1, 10'd5}};
        dir_rows[9]  = {{OP_SPARE, 10'd6, KIND_NORMAL, SIDE_LEFT, 10'd0, 10'd0},
                        1'b1, {1'b0, 1'b1, 10'd1023, 1'b1, 10'd5}};
        dir_rows[10] = {{OP_FINISH, 10'd5, KIND_NORMAL, SIDE_LEFT, 10'd0, 10'd0},
                        1'b1, {1'b1, 1'b1, 10'd1023, 1'b1, 10'd6}};
        dir_rows[11] = {{OP_FINISH, 10'd5, KIND_NORMAL, SIDE_LEFT, 10'd0, 10'd0},
                        1'b1, {1'b0, 1'b1, 10'd1023, 1'b1, 10'd6}};
        dir_rows[12] = {{OP_ADD, 10'd5, KIND_NORMAL, SIDE_LEFT, 10'd0, 10'd0},
                        1'b1, {1'b0, 1'b1, 10'd1023, 1'b1, 10'd6}};
        dir_rows[13] = {{OP_FINISH, 10'd1023, KIND_NORMAL, SIDE_LEFT, 10'd0, 10'd0},
                        1'b1, {1'b1, 1'b0, 10'd0, 1'b1, 10'd6}};
        dir_rows[14] = {{OP_ADD, 10'h2AA, KIND_FISHING, SIDE_LEFT, 10'd1000, 10'h155},
                        1'b0, 23'd0};
        dir_rows[15] = {{OP_ADD, 10'h155, KIND_PATROL, SIDE_LEFT, 10'h2AA, 10'd0},
                        1'b0, 23'd0};
        dir_rows[16] = {{OP_FINISH, 10'd7, KIND_SPARE, SIDE_SPARE, 10'h3FF, 10'h3FF},
                        1'b0, 23'd0};

        phase_mode  = '{1, 2, 3, 0, 1, 3, 2, 1};
        phase_width = '{1023, 0, 500, 1, 999, 1000, 2, 1023};
        // last phase fills the table and keeps adding into it
        phase_add   = '{9, 9, 9, 9, 9, 9, 9, 55};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_N; r++)
            offer(dir_rows[r].stim, dir_rows[r].known, dir_rows[r].want);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            write_reg(CFG_SELECT_MODE, phase_mode[p]);
            write_reg(CFG_CHANNEL_WIDTH, phase_width[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer(make_item(phase_add[p]), 1'b0, '0);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // result side
    out_item_t want_pick;
    int        picks_seen = 0;
    int        stall_pct = 0;
    int        pattern_left = 0;
    int        hold_left = 0;
    logic      held_off = 1'b0;

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                picks_seen++;
                if (pending_picks.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, result);
                    mismatches++;
                end
                else
                begin
                    want_pick = pending_picks.pop_front();
                    check_field("accepted", want_pick.accepted, result.accepted);
                    check_field("left_valid", want_pick.left_valid, result.left_valid);
                    check_field("left_id", want_pick.left_id, result.left_id);
                    check_field("right_valid", want_pick.right_valid, result.right_valid);
                    check_field("right_id", want_pick.right_id, result.right_id);
                end
            end
            if (pattern_left == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                pattern_left = $urandom_range(20, 80);
            end
            pattern_left--;
            // hold off once so the input side backs up and raises full
            if (!held_off && picks_seen >= HOLD_AT)
            begin
                held_off = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog: count cycles with no beat on either side
    int stuck_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || cfg_we)
                stuck_cycles <= 0;
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tcmks_pkg.sv
rtl/tcmks_front.sv
rtl/tcmks_back.sv
rtl/two_class_min_key_selector_top.sv
verif/testbench.sv
